[design/assert_macros.svh]
// Assertion macros shared by the integral image RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define II_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define II_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

[design/ii_pkg.sv]
`timescale 1ns / 1ps
// Package for the integral image block: sizes, register indexes and payload types.
// No dependencies; used by every module of the block except the generic ii_ram.
package ii_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_CHANNELS = 2;

  localparam int LB_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W   = $clog2(LB_DEPTH);
  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EW_W     = $clog2(MAX_WIDTH + 1);
  localparam int NCH_W    = $clog2(MAX_CHANNELS + 1);

  localparam int SUM_W    = 32;
  localparam int SAMPLE_W = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_WIDTH_W = 13;
  localparam int CHAN_CFG_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_INPUT  = 2'd2;

  localparam int RST_ROW_WIDTH  = 640;
  localparam int RST_WIDTH_EFF  = (RST_ROW_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_ROW_WIDTH;
  localparam int RST_CHAN_EFF   = 1;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_start;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             row_end;
  } out_t;

  // One classified sample handed from front to back.
  typedef struct packed {
    logic [SUM_W-1:0]  rsum;
    logic [ADDR_W-1:0] addr;
    logic              first_row;
    logic              row_end;
  } qent_t;

endpackage

[design/integral_image.sv]
`timescale 1ns / 1ps
// Integral image (summed-area table), one 32-bit sum per input sample, raster order.
// Each sample is registered in the queue, then in the back-end stage, then in the output register.
// Throughput: one sample per clock if out_ready, via 2-entry queue and output register.
// Reset (synchronous, rst high): positions, row sums and handshakes clear, row width 640,
// one channel, unsigned; the line buffer is not cleared since the first row never uses it.
module integral_image import ii_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  // Handshake and payload between the front end and the queue.
  logic  push;
  qent_t push_data;
  logic  q_ready;

  // Handshake and payload between the queue and the back end.
  logic  q_valid;
  logic  pop;
  qent_t q_head;

  // The front end holds the configuration and the raster position. For each
  // transfer it works out the channel, the pixel column, whether the sample is
  // on the first row of the frame, the running row sum for that channel and the
  // line-buffer address. It only stalls when the queue is full, so it never
  // waits on the output side directly.
  ii_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_ready   (q_ready),
    .push      (push),
    .push_data (push_data)
  );

  // A two-entry queue separates the two halves, so input ready is a registered
  // term and does not depend combinationally on out_ready.
  ii_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (pop),
    .head      (q_head)
  );

  // The back end reads the value stored for the same column and channel on the
  // previous row, adds the row sum, writes the result back and loads the output
  // register. When one address is revisited on consecutive samples (a one-pixel,
  // one-channel row) the just-written value is forwarded around the memory.
  ii_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/ii_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ii_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ii_front.sv]
`timescale 1ns / 1ps
// Front end: configuration registers, raster position tracking and per-channel row sums.
// Depends on ii_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ii_front import ii_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  q_ready,
  output logic                  push,
  output qent_t                 push_data
);

  logic [EW_W-1:0]  width_eff;
  logic [NCH_W-1:0] nch_eff;
  logic             signed_mode;

  logic [COL_W-1:0] col;
  logic [CH_W-1:0]  chan;
  logic             first_row;
  logic [SUM_W-1:0] rsum [MAX_CHANNELS];

  logic [COL_W-1:0] col_cur;
  logic [CH_W-1:0]  ch_cur;
  logic             first_cur;
  logic [SUM_W-1:0] rsum_cur;
  logic [SUM_W-1:0] val;
  logic [SUM_W-1:0] new_sum;
  logic             last_chan;
  logic             last_col;
  logic [SUM_W-1:0] rsum_next [MAX_CHANNELS];

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    col_cur   = in_data.frame_start ? '0 : col;
    first_cur = in_data.frame_start ? 1'b1 : first_row;
    if (in_data.frame_start) begin
      ch_cur = '0;
    end else if (32'(chan) >= 32'(nch_eff)) begin
      ch_cur = CH_W'(32'(nch_eff) - 32'd1);
    end else begin
      ch_cur = chan;
    end
    rsum_cur = in_data.frame_start ? '0 : rsum[ch_cur];
    if (signed_mode) begin
      val = {{(SUM_W - SAMPLE_W){in_data.sample[SAMPLE_W-1]}}, in_data.sample};
    end else begin
      val = {{(SUM_W - SAMPLE_W){1'b0}}, in_data.sample};
    end
    new_sum   = rsum_cur + val;
    last_chan = (32'(ch_cur) + 32'd1) >= 32'(nch_eff);
    last_col  = (32'(col_cur) + 32'd1) >= 32'(width_eff);

    push_data.rsum      = new_sum;
    push_data.addr      = ADDR_W'(32'(col_cur) * MAX_CHANNELS + 32'(ch_cur));
    push_data.first_row = first_cur;
    push_data.row_end   = last_chan && last_col;

    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (in_data.frame_start || (last_chan && last_col)) begin
        rsum_next[i] = '0;
      end else begin
        rsum_next[i] = rsum[i];
      end
    end
    if (!(last_chan && last_col)) begin
      rsum_next[ch_cur] = new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff   <= EW_W'(RST_WIDTH_EFF);
      nch_eff     <= NCH_W'(RST_CHAN_EFF);
      signed_mode <= 1'b0;
      col         <= '0;
      chan        <= '0;
      first_row   <= 1'b1;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        rsum[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROW_WIDTH: begin
            if (cfg_data[ROW_WIDTH_W-1:0] == '0) begin
              width_eff <= EW_W'(1);
            end else if (32'(cfg_data[ROW_WIDTH_W-1:0]) > 32'(MAX_WIDTH)) begin
              width_eff <= EW_W'(MAX_WIDTH);
            end else begin
              width_eff <= EW_W'(cfg_data[ROW_WIDTH_W-1:0]);
            end
          end
          CFG_CHANNEL_COUNT: begin
            if (cfg_data[CHAN_CFG_W-1:0] == '0) begin
              nch_eff <= NCH_W'(1);
            end else if (32'(cfg_data[CHAN_CFG_W-1:0]) > 32'(MAX_CHANNELS)) begin
              nch_eff <= NCH_W'(MAX_CHANNELS);
            end else begin
              nch_eff <= NCH_W'(cfg_data[CHAN_CFG_W-1:0]);
            end
          end
          CFG_SIGNED_INPUT: begin
            signed_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (push) begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
          rsum[i] <= rsum_next[i];
        end
        if (last_chan) begin
          chan <= '0;
          if (last_col) begin
            col       <= '0;
            first_row <= 1'b0;
          end else begin
            col       <= col_cur + COL_W'(1);
            first_row <= first_cur;
          end
        end else begin
          chan      <= ch_cur + CH_W'(1);
          col       <= col_cur;
          first_row <= first_cur;
        end
      end
    end
  end

  // A finished row always returns the position to column zero, past the first row.
  `II_ASSERT_NEXT(fr_row_end_wraps, push && push_data.row_end, (col == '0) && !first_row)

endmodule

[design/ii_queue.sv]
`timescale 1ns / 1ps
// Short register FIFO that carries classified samples from front to back.
// Depends on ii_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ii_queue import ii_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  ready,
  output logic  valid,
  input  logic  pop,
  output qent_t head
);

  qent_t            slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;

  assign ready = count < QC_W'(Q_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QC_W'(1);
      end else if (pop && !push) begin
        count <= count - QC_W'(1);
      end
    end
  end

  `II_ASSERT_ALWAYS(q_count_bound, count <= QC_W'(Q_DEPTH))
  `II_ASSERT_ALWAYS(q_no_pop_empty, !pop || valid)

endmodule

[design/ii_back.sv]
`timescale 1ns / 1ps
// Back end: line buffer read, vertical add with forwarding, write-back and output register.
// Depends on ii_pkg, ii_ram and assert_macros.svh.
`include "assert_macros.svh"
module ii_back import ii_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  qent_t q_head,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic             bv;
  qent_t            b_ent;
  logic             fwd;
  logic [SUM_W-1:0] fwd_data;
  logic [SUM_W-1:0] rdata;
  logic [SUM_W-1:0] above;
  logic [SUM_W-1:0] total;
  logic             b_adv;
  logic             ov;
  out_t             o_data;

  assign b_adv = bv && (!ov || out_ready);
  assign pop   = q_valid && (!bv || b_adv);

  always_comb begin
    if (b_ent.first_row) begin
      above = '0;
    end else if (fwd) begin
      above = fwd_data;
    end else begin
      above = rdata;
    end
    total = b_ent.rsum + above;
  end

  ii_ram #(
    .WIDTH(SUM_W),
    .DEPTH(LB_DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (b_adv),
    .waddr (b_ent.addr),
    .wdata (total),
    .re    (pop),
    .raddr (q_head.addr),
    .rdata (rdata)
  );

  // A read issued at the same edge as the previous sample's write to the same address sees
  // stale data, so that write is captured and used in place of the memory output.
  always_ff @(posedge clk) begin
    if (pop) begin
      b_ent    <= q_head;
      fwd      <= b_adv && (b_ent.addr == q_head.addr);
      fwd_data <= total;
    end
    if (b_adv) begin
      o_data.sum     <= total;
      o_data.row_end <= b_ent.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (pop) begin
        bv <= 1'b1;
      end else if (b_adv) begin
        bv <= 1'b0;
      end
      if (b_adv) begin
        ov <= 1'b1;
      end else if (out_ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign out_valid = ov;
  assign out_data  = o_data;

  `II_ASSERT_NEXT(bk_adv_loads_out, b_adv, ov)

endmodule
